// ----- rtl/asfp_pkg.sv -----
// Package with format codes, G.711 segment tables and the stage item type.
package asfp_pkg;

  // Sample format codes held in the format register.
  localparam logic [2:0] FMT_U8    = 3'd0;
  localparam logic [2:0] FMT_S8    = 3'd1;
  localparam logic [2:0] FMT_ULAW  = 3'd2;
  localparam logic [2:0] FMT_ALAW  = 3'd3;
  localparam logic [2:0] FMT_S16LE = 3'd4;
  localparam logic [2:0] FMT_U16LE = 3'd5;

  localparam logic [7:0]  ALAW_XOR_MASK = 8'h55;
  localparam logic [7:0]  BYTE_SIGN     = 8'h80;
  localparam logic [15:0] WORD_SIGN     = 16'h8000;

  // Segment base magnitudes of the mu-law expansion.
  function automatic logic [15:0] ulaw_base(input logic [2:0] seg);
    logic [15:0] base;
    case (seg)
      3'd0:    base = 16'd0;
      3'd1:    base = 16'd132;
      3'd2:    base = 16'd396;
      3'd3:    base = 16'd924;
      3'd4:    base = 16'd1980;
      3'd5:    base = 16'd4092;
      3'd6:    base = 16'd8316;
      3'd7:    base = 16'd16764;
      default: base = 16'd0;
    endcase
    return base;
  endfunction

  // Segment base magnitudes of the A-law expansion.
  function automatic logic [15:0] alaw_base(input logic [2:0] seg);
    logic [15:0] base;
    case (seg)
      3'd0:    base = 16'd0;
      3'd1:    base = 16'd264;
      3'd2:    base = 16'd528;
      3'd3:    base = 16'd1056;
      3'd4:    base = 16'd2112;
      3'd5:    base = 16'd4224;
      3'd6:    base = 16'd8448;
      3'd7:    base = 16'd16896;
      default: base = 16'd0;
    endcase
    return base;
  endfunction

  // One item that will give a sample, as held between the two stages.
  typedef struct packed {
    logic [2:0] fmt;
    logic [7:0] hi_byte;
    logic [7:0] lo_byte;
  } asfp_item_t;

endpackage

// ----- rtl/asfp_capture.sv -----
// Input stage: format register, 16-bit byte pairing and the input register.
module asfp_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_fmt,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                s1_take,
  output logic                s1_valid,
  output asfp_pkg::asfp_item_t s1_item
);
  import asfp_pkg::*;

  logic [2:0] fmt_r, fmt_nxt;
  logic       due_r, due_nxt;
  logic [7:0] held_r, held_nxt;
  logic       s1_valid_r, s1_valid_nxt;
  asfp_item_t s1_item_r, s1_item_nxt;
  logic       accept;
  logic       is_wide;
  logic       is_narrow;
  logic       produce;

  assign in_ready  = !s1_valid_r || s1_take;
  assign accept    = in_valid && in_ready;
  assign is_wide   = (fmt_r == FMT_S16LE) || (fmt_r == FMT_U16LE);
  assign is_narrow = (fmt_r == FMT_U8) || (fmt_r == FMT_S8) ||
                     (fmt_r == FMT_ULAW) || (fmt_r == FMT_ALAW);
  // An item gives a sample for 8-bit formats, or as the high byte of a pair.
  assign produce   = accept && (is_narrow || (is_wide && due_r));

  // Format register, pairing state and stage register update.
  always_comb begin
    fmt_nxt      = fmt_r;
    due_nxt      = due_r;
    held_nxt     = held_r;
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      fmt_nxt = cfg_fmt;
      due_nxt = 1'b0;
    end else if (accept && is_wide) begin
      due_nxt = !due_r;
      if (!due_r) begin
        held_nxt = in_data_byte;
      end
    end
    if (produce) begin
      s1_valid_nxt        = 1'b1;
      s1_item_nxt.fmt     = fmt_r;
      s1_item_nxt.hi_byte = in_data_byte;
      s1_item_nxt.lo_byte = held_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_U8;
      due_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      fmt_r      <= fmt_nxt;
      due_r      <= due_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    held_r    <= held_nxt;
    s1_item_r <= s1_item_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

// ----- rtl/asfp_decode.sv -----
// Decode logic: turns one captured item into a left-justified 32-bit sample.
module asfp_decode (
  input  asfp_pkg::asfp_item_t item,
  output logic [31:0]          sample
);
  import asfp_pkg::*;

  logic [7:0]  ul_c;
  logic [15:0] ul_mag;
  logic [15:0] ul_lin;
  logic [7:0]  al_c;
  logic [15:0] al_mag;
  logic [15:0] al_lin;
  logic [15:0] pair;

  // Mu-law: invert, then segment base plus shifted mantissa, sign at bit 7.
  always_comb begin
    ul_c   = ~item.hi_byte;
    ul_mag = ulaw_base(ul_c[6:4]) +
             ({12'd0, ul_c[3:0]} << ({1'b0, ul_c[6:4]} + 4'd3));
    ul_lin = ul_c[7] ? (16'd0 - ul_mag) : ul_mag;
  end

  // A-law: toggle even bits; the lowest segment is linear with a half step.
  always_comb begin
    al_c = item.hi_byte ^ ALAW_XOR_MASK;
    if (al_c[6:4] != 3'd0) begin
      al_mag = alaw_base(al_c[6:4]) +
               ({12'd0, al_c[3:0]} << ({1'b0, al_c[6:4]} + 4'd3));
    end else begin
      al_mag = {8'd0, al_c[3:0], 4'd8};
    end
    al_lin = al_c[7] ? al_mag : (16'd0 - al_mag);
  end

  // Select the decoding by the format the item was taken under.
  always_comb begin
    pair = {item.hi_byte, item.lo_byte};
    case (item.fmt)
      FMT_U8:    sample = {item.hi_byte ^ BYTE_SIGN, 24'd0};
      FMT_S8:    sample = {item.hi_byte, 24'd0};
      FMT_ULAW:  sample = {ul_lin, 16'd0};
      FMT_ALAW:  sample = {al_lin, 16'd0};
      FMT_S16LE: sample = {pair, 16'd0};
      FMT_U16LE: sample = {pair ^ WORD_SIGN, 16'd0};
      default:   sample = 32'd0;
    endcase
  end

endmodule

// ----- rtl/audio_sample_format_to_pcm32.sv -----
// Top level: raw audio byte stream to 32-bit left-justified PCM samples.
//
// The input channel (in_valid/in_ready/in_data_byte) takes one raw byte per
// item. The output channel (out_valid/out_ready/out_sample) gives one signed
// 32-bit sample per completed item. 8-bit formats give a sample for every
// byte; the 16-bit little-endian formats take the low byte first, which
// gives no sample, and the high byte then gives one.
// The configuration channel (cfg_valid/cfg_ready/cfg_sample_format) sets the
// format and drops any half-received 16-bit pair; it is always ready. The
// user must write it only while the block is idle; the block does not enforce it.
// An accepted byte passes the input register, then the decode into the
// output register, which raises out_valid. Throughput is one byte every
// cycle while out_ready holds high; the two registers form a pipeline with
// a flow-through ready, so a byte is accepted while a finished sample waits
// to be taken. When the receiver stalls, the sample holds in the output
// register and one more item can wait in the input register before in_ready
// drops. Reset clears the format to 8-bit unsigned, the pairing state and
// both valid flags.
module audio_sample_format_to_pcm32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_sample_format,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample
);
  import asfp_pkg::*;

  logic        s1_valid;
  asfp_item_t  s1_item;
  logic        s1_take;
  logic [31:0] dec_sample;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_sample_r, out_sample_nxt;

  assign cfg_ready = 1'b1;

  // The output register is free when empty or being read this cycle.
  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  asfp_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_fmt      (cfg_sample_format),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .s1_take      (s1_take),
    .s1_valid     (s1_valid),
    .s1_item      (s1_item)
  );

  asfp_decode u_decode (
    .item   (s1_item),
    .sample (dec_sample)
  );

  // Output register update.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_take) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = dec_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// ----- rtl/asfp_checker.sv -----
// Port-level checker for the audio sample decoder, bound to the top level.
module asfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_sample
);

  // The block comes out of reset with no sample pending.
  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid)
    else $error("out_valid set right after reset");

  // With the output register empty, the pipeline must take a new item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while no sample is pending");

  // A new sample appears only after the item that completed it has passed the input register.
  a_rise_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && $past(rst_n, 2)) |-> $past(in_valid && in_ready, 2))
    else $error("sample appeared without a matching input item");

  // A stalled sample holds its value.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("stalled sample changed or dropped");

endmodule

bind audio_sample_format_to_pcm32 asfp_checker u_asfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample)
);
